### hdl/assert_macros.svh
// Assertion macros used by the RTL of the ranging block.
// Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/dtwr_pkg.sv
// Shared constants and types of the two-way ranging distance unit.
// No dependencies.
`timescale 1ns / 1ps
package dtwr_pkg;
  localparam int STAMP_BITS_DEF = 40;
  localparam int MPT_W          = 32;
  localparam int DIST_W         = 48;
  localparam int FRAC_SHIFT     = 16;
  localparam logic [MPT_W-1:0] MPT_RESET = 32'd20150974;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // sideband travelling with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;
endpackage

### hdl/ds_twr_distance_unit.sv
// Double-sided two-way ranging distance unit.
// Takes six timestamps per item and returns a signed distance in 1/65536 m.
// Channels: in_* carries one exchange's timestamps, out_* one result; each
// moves an item on a clock edge with valid high and stall low.
// cfg_* writes meters_per_tick (unsigned Q0.32); cfg_ready is always high.
// Write it only while no item is in flight.
// Throughput: one item per cycle unless out_stall holds a valid result.
// Pipeline: 4 front-end stages, 2 scaling stages, one division cell
// per quotient bit (2*STAMP_BITS+32 cells, 112 at the default) and
// 1 output register.
// The division chain of cells sets the latency.
// The whole pipeline advances together: when out_stall holds a valid
// result, every stage freezes and in_stall is raised.
// Reset (synchronous, rst_n low) empties the pipeline and sets
// meters_per_tick to 20150974.
// A zero denominator gives distance 0 with status 1; a result outside
// 48 signed bits saturates with status 2.
// Depends on dtwr_pkg, dtwr_prod, dtwr_scale, dtwr_div_cell.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ds_twr_distance_unit import dtwr_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [STAMP_BITS-1:0]    in_poll_tx_time,
  input  logic [STAMP_BITS-1:0]    in_poll_rx_time,
  input  logic [STAMP_BITS-1:0]    in_resp_tx_time,
  input  logic [STAMP_BITS-1:0]    in_resp_rx_time,
  input  logic [STAMP_BITS-1:0]    in_final_tx_time,
  input  logic [STAMP_BITS-1:0]    in_final_rx_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DIST_W-1:0] out_distance,
  output logic [1:0]               out_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MPT_W-1:0]         cfg_meters_per_tick
);
  localparam int SB  = STAMP_BITS;
  localparam int PW  = 2 * SB;
  localparam int DW  = SB + 2;
  localparam int QW  = PW + MPT_W;
  localparam int FW  = QW - FRAC_SHIFT;
  localparam int XW  = (FW > DIST_W) ? FW : DIST_W;
  localparam logic [XW-1:0] POS_LIM = XW'({1'b0, {(DIST_W-1){1'b1}}});
  localparam logic [XW-1:0] NEG_LIM = XW'({1'b1, {(DIST_W-1){1'b0}}});

  logic             adv;
  logic [MPT_W-1:0] mpt_r;

  ctl_t             ctl_p, ctl_s;
  logic [DW-1:0]    den_p, den_s;
  logic [PW-1:0]    mag_p;
  logic [QW-1:0]    prod_s;

  ctl_t             ctl_c [QW+1];
  logic [DW-1:0]    den_c [QW+1];
  logic [DW-1:0]    rem_c [QW+1];
  logic [QW-1:0]    acc_c [QW+1];

  logic                     out_valid_r;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;
  status_t                  status_r, status_nxt;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= MPT_RESET;
    end else if (cfg_valid) begin
      mpt_r <= cfg_meters_per_tick;
    end
  end

  dtwr_prod #(.SB(SB)) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .valid_i  (in_valid),
    .poll_tx  (in_poll_tx_time),
    .poll_rx  (in_poll_rx_time),
    .resp_tx  (in_resp_tx_time),
    .resp_rx  (in_resp_rx_time),
    .final_tx (in_final_tx_time),
    .final_rx (in_final_rx_time),
    .ctl_o    (ctl_p),
    .den_o    (den_p),
    .mag_o    (mag_p)
  );

  dtwr_scale #(.SB(SB)) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .ctl_i  (ctl_p),
    .den_i  (den_p),
    .mag_i  (mag_p),
    .mpt_i  (mpt_r),
    .ctl_o  (ctl_s),
    .den_o  (den_s),
    .prod_o (prod_s)
  );

  assign ctl_c[0] = ctl_s;
  assign den_c[0] = den_s;
  assign rem_c[0] = '0;
  assign acc_c[0] = prod_s;

  for (genvar g = 0; g < QW; g++) begin : g_div
    dtwr_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i (ctl_c[g]),
      .den_i (den_c[g]),
      .rem_i (rem_c[g]),
      .acc_i (acc_c[g]),
      .ctl_o (ctl_c[g+1]),
      .den_o (den_c[g+1]),
      .rem_o (rem_c[g+1]),
      .acc_o (acc_c[g+1])
    );
  end

  // drop 16 fraction bits, then clamp to the 48-bit signed range
  logic [FW-1:0] frac_q;
  logic [XW-1:0] mag_x, neg_x;
  assign frac_q = acc_c[QW][QW-1:FRAC_SHIFT];
  assign mag_x  = XW'(frac_q);
  assign neg_x  = '0 - mag_x;

  always_comb begin
    dist_nxt   = DIST_W'(mag_x);
    status_nxt = ST_OK;
    if (den_c[QW] == '0) begin
      dist_nxt   = '0;
      status_nxt = ST_ZERO;
    end else if (ctl_c[QW].neg) begin
      if (mag_x > NEG_LIM) begin
        dist_nxt   = NEG_LIM[DIST_W-1:0];
        status_nxt = ST_SAT;
      end else begin
        dist_nxt = neg_x[DIST_W-1:0];
      end
    end else if (mag_x > POS_LIM) begin
      dist_nxt   = POS_LIM[DIST_W-1:0];
      status_nxt = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_c[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r   <= dist_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;
  assign out_status   = status_r;

  `ASSERT_HOLDS(a_stall_only_when_blocked, clk, rst_n,
                !in_stall || (out_valid && out_stall))
  `ASSERT_HOLDS(a_zero_den_gives_zero, clk, rst_n,
                !(out_valid && out_status == ST_ZERO) || out_distance == '0)
  `ASSERT_HOLDS(a_sat_at_range_end, clk, rst_n,
                !(out_valid && out_status == ST_SAT)
                || out_distance == POS_LIM[DIST_W-1:0]
                || out_distance == NEG_LIM[DIST_W-1:0])
  `ASSERT_NEXT(a_cfg_takes_effect, clk, rst_n, cfg_valid,
               mpt_r == $past(cfg_meters_per_tick))
endmodule

### hdl/dtwr_prod.sv
// Front end: intervals, denominator and signed cross-product difference.
// Depends on dtwr_pkg.
`timescale 1ns / 1ps
module dtwr_prod import dtwr_pkg::*; #(
  parameter int SB = STAMP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [SB-1:0]     poll_tx,
  input  logic [SB-1:0]     poll_rx,
  input  logic [SB-1:0]     resp_tx,
  input  logic [SB-1:0]     resp_rx,
  input  logic [SB-1:0]     final_tx,
  input  logic [SB-1:0]     final_rx,
  output ctl_t              ctl_o,
  output logic [SB+1:0]     den_o,
  output logic [2*SB-1:0]   mag_o
);
  localparam int H  = (SB + 1) / 2;
  localparam int HW = SB - H;
  localparam int PW = 2 * SB;
  localparam int DW = SB + 2;

  // stage A: intervals
  logic [SB-1:0] rd1_r, rd2_r, rp1_r, rp2_r;
  logic [DW-1:0] den_a_r;
  logic          va_r;
  logic [SB-1:0] rd1, rd2, rp1, rp2;
  assign rd1 = resp_rx - poll_tx;
  assign rp1 = resp_tx - poll_rx;
  assign rp2 = final_tx - resp_rx;
  assign rd2 = final_rx - resp_tx;

  // stage B: partial products of round1*round2 and reply1*reply2
  logic [2*H-1:0]  a_ll_r, b_ll_r;
  logic [H+HW-1:0] a_lh_r, a_hl_r, b_lh_r, b_hl_r;
  logic [2*HW-1:0] a_hh_r, b_hh_r;
  logic [DW-1:0]   den_b_r;
  logic            vb_r;

  // stage C: full products
  logic [PW-1:0] pa_r, pb_r;
  logic [DW-1:0] den_c_r;
  logic          vc_r;

  // stage D: magnitude and sign
  logic [PW-1:0] mag_r;
  logic [DW-1:0] den_d_r;
  ctl_t          ctl_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      ctl_d_r <= '0;
    end else if (en) begin
      va_r          <= valid_i;
      vb_r          <= va_r;
      vc_r          <= vb_r;
      ctl_d_r.valid <= vc_r;
      ctl_d_r.neg   <= pa_r < pb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd1_r   <= rd1;
      rd2_r   <= rd2;
      rp1_r   <= rp1;
      rp2_r   <= rp2;
      den_a_r <= DW'(rd1) + DW'(rd2) + DW'(rp1) + DW'(rp2);

      a_ll_r  <= rd1_r[H-1:0] * rd2_r[H-1:0];
      a_lh_r  <= rd1_r[H-1:0] * rd2_r[SB-1:H];
      a_hl_r  <= rd1_r[SB-1:H] * rd2_r[H-1:0];
      a_hh_r  <= rd1_r[SB-1:H] * rd2_r[SB-1:H];
      b_ll_r  <= rp1_r[H-1:0] * rp2_r[H-1:0];
      b_lh_r  <= rp1_r[H-1:0] * rp2_r[SB-1:H];
      b_hl_r  <= rp1_r[SB-1:H] * rp2_r[H-1:0];
      b_hh_r  <= rp1_r[SB-1:H] * rp2_r[SB-1:H];
      den_b_r <= den_a_r;

      pa_r    <= PW'(a_ll_r) + (PW'(a_lh_r) << H) + (PW'(a_hl_r) << H)
                 + (PW'(a_hh_r) << (2 * H));
      pb_r    <= PW'(b_ll_r) + (PW'(b_lh_r) << H) + (PW'(b_hl_r) << H)
                 + (PW'(b_hh_r) << (2 * H));
      den_c_r <= den_b_r;

      mag_r   <= (pa_r < pb_r) ? (pb_r - pa_r) : (pa_r - pb_r);
      den_d_r <= den_c_r;
    end
  end

  assign ctl_o = ctl_d_r;
  assign den_o = den_d_r;
  assign mag_o = mag_r;
endmodule

### hdl/dtwr_scale.sv
// Scales the numerator magnitude by meters-per-tick in 32-bit slices.
// Depends on dtwr_pkg.
`timescale 1ns / 1ps
module dtwr_scale import dtwr_pkg::*; #(
  parameter int SB = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ctl_t                  ctl_i,
  input  logic [SB+1:0]         den_i,
  input  logic [2*SB-1:0]       mag_i,
  input  logic [MPT_W-1:0]      mpt_i,
  output ctl_t                  ctl_o,
  output logic [SB+1:0]         den_o,
  output logic [2*SB+MPT_W-1:0] prod_o
);
  localparam int PW = 2 * SB;
  localparam int QW = PW + MPT_W;
  localparam int NC = (PW + MPT_W - 1) / MPT_W;
  localparam int DW = SB + 2;

  logic [NC*MPT_W-1:0]   mag_pad;
  logic [2*MPT_W-1:0]    part_r [NC];
  ctl_t                  ctl_e_r, ctl_f_r;
  logic [DW-1:0]         den_e_r, den_f_r;
  logic [QW-1:0]         sum, prod_r;

  assign mag_pad = (NC*MPT_W)'(mag_i);

  always_comb begin
    sum = '0;
    for (int i = 0; i < NC; i++) begin
      sum = sum + (QW'(part_r[i]) << (MPT_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r <= '0;
      ctl_f_r <= '0;
    end else if (en) begin
      ctl_e_r <= ctl_i;
      ctl_f_r <= ctl_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        part_r[i] <= mag_pad[MPT_W*i +: MPT_W] * mpt_i;
      end
      den_e_r <= den_i;
      den_f_r <= den_e_r;
      prod_r  <= sum;
    end
  end

  assign ctl_o  = ctl_f_r;
  assign den_o  = den_f_r;
  assign prod_o = prod_r;
endmodule

### hdl/dtwr_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on dtwr_pkg.
`timescale 1ns / 1ps
module dtwr_div_cell import dtwr_pkg::*; #(
  parameter int DW = STAMP_BITS_DEF + 2,
  parameter int QW = 2 * STAMP_BITS_DEF + MPT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ctl_t          ctl_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] acc_i,
  output ctl_t          ctl_o,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] acc_o
);
  ctl_t          ctl_r;
  logic [DW-1:0] den_r, rem_r;
  logic [QW-1:0] acc_r;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  // acc holds the unused dividend bits on top, quotient bits enter below
  assign rem_sh  = {rem_i, acc_i[QW-1]};
  assign ge      = rem_sh >= {1'b0, den_i};
  assign rem_sub = rem_sh - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      acc_r <= {acc_i[QW-2:0], ge};
    end
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign acc_o = acc_r;
endmodule
